/* sv/integer_add_sub_mul_div_unit_macros.svh */
// Assertion macros for the integer add/subtract/multiply/divide unit.
// Depends on nothing; included by the top level only.
`ifndef INTEGER_ADD_SUB_MUL_DIV_UNIT_MACROS_SVH
`define INTEGER_ADD_SUB_MUL_DIV_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IASMD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset too.
`define IASMD_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/iasmd_pkg.sv */
// Shared types and command codes of the integer add/subtract/multiply/divide unit.
// Depends on nothing.
`default_nettype none
package iasmd_pkg;
    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_ADD = 2'd0;
    localparam cmd_t CMD_SUB = 2'd1;
    localparam cmd_t CMD_MUL = 2'd2;
    localparam cmd_t CMD_DIV = 2'd3;
endpackage
`default_nettype wire

/* sv/iasmd_div_step.sv */
// One restoring division step: shifts in one dividend bit and forms one quotient bit.
// Depends on iasmd_pkg.
`default_nettype none
module iasmd_div_step
    import iasmd_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic [WIDTH-1:0] rem_in,
    input  wire logic [WIDTH-1:0] quo_in,
    input  wire logic [WIDTH-1:0] divisor,
    output logic      [WIDTH-1:0] rem_out,
    output logic      [WIDTH-1:0] quo_out
);
    logic [WIDTH:0] trial;
    logic [WIDTH:0] diff;
    logic           fits;

    always_comb begin
        trial   = {rem_in, quo_in[WIDTH-1]};
        diff    = trial - {1'b0, divisor};
        fits    = (trial >= {1'b0, divisor});
        rem_out = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        quo_out = {quo_in[WIDTH-2:0], fits};
    end
endmodule
`default_nettype wire

/* sv/integer_add_sub_mul_div_unit.sv */
// Top level of the unsigned add/subtract/multiply/divide unit.
// Depends on iasmd_pkg, iasmd_div_step and integer_add_sub_mul_div_unit_macros.svh.
//
// Channel   Direction  tdata (low bit up)                     tuser
// s_        in         left_operand, right_operand            command
// m_        out        result_value, remainder_value          divide_by_zero
//
// One request may enter every cycle unless a stalled output holds the pipeline.
// The divider takes one restoring step per stage over WIDTH stages.
// Multiply uses three half-width products in stage 1 and a sum in stage 2.
// Reset clears all stage valid bits. A stalled output holds the whole pipeline.
`default_nettype none
`include "integer_add_sub_mul_div_unit_macros.svh"
module integer_add_sub_mul_div_unit
    import iasmd_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // left_operand, right_operand, zero fill
    input  wire logic [((2*WIDTH+7)/8)*8-1:0]        s_tdata,
    // command
    input  wire logic [1:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // result_value, remainder_value, zero fill
    output logic      [((2*WIDTH+7)/8)*8-1:0]        m_tdata,
    // divide_by_zero
    output logic                                     m_tuser
);
    localparam int DW = ((2*WIDTH+7)/8)*8;
    localparam int H  = WIDTH/2;
    localparam int NS = WIDTH + 1;

    typedef struct packed {
        cmd_t             cmd;
        logic             dz;
        logic [WIDTH-1:0] dvs;
        logic [WIDTH-1:0] rem;
        logic [WIDTH-1:0] quo;
        logic [WIDTH-1:0] p0;
        logic [WIDTH-1:0] p1;
        logic [WIDTH-1:0] p2;
    } stage_t;

    logic   vld_reg [NS];
    stage_t stg_reg [NS];
    stage_t stg_next [NS];
    logic   adv;

    assign adv      = !vld_reg[NS-1] || m_tready;
    assign s_tready = adv;

    always_comb begin
        stg_next[0]     = '0;
        stg_next[0].cmd = s_tuser;
        stg_next[0].dvs = s_tdata[2*WIDTH-1:WIDTH];
        stg_next[0].quo = s_tdata[WIDTH-1:0];
        stg_next[0].dz  = (s_tuser == CMD_DIV) && (s_tdata[2*WIDTH-1:WIDTH] == '0);
    end

    for (genvar k = 1; k < NS; k++) begin : g_stage
        logic [WIDTH-1:0] rem_s;
        logic [WIDTH-1:0] quo_s;

        iasmd_div_step #(.WIDTH(WIDTH)) u_step (
            .rem_in  (stg_reg[k-1].rem),
            .quo_in  (stg_reg[k-1].quo),
            .divisor (stg_reg[k-1].dvs),
            .rem_out (rem_s),
            .quo_out (quo_s)
        );

        always_comb begin
            stg_next[k]     = stg_reg[k-1];
            stg_next[k].rem = rem_s;
            stg_next[k].quo = quo_s;
            if (k == 1) begin
                unique case (stg_reg[k-1].cmd)
                    CMD_ADD: stg_next[k].p0 = stg_reg[k-1].quo + stg_reg[k-1].dvs;
                    CMD_SUB: stg_next[k].p0 = stg_reg[k-1].quo - stg_reg[k-1].dvs;
                    CMD_MUL: begin
                        stg_next[k].p0 = WIDTH'(stg_reg[k-1].quo[H-1:0])
                                       * WIDTH'(stg_reg[k-1].dvs[H-1:0]);
                        stg_next[k].p1 = WIDTH'(stg_reg[k-1].quo[WIDTH-1:H])
                                       * WIDTH'(stg_reg[k-1].dvs[H-1:0]);
                        stg_next[k].p2 = WIDTH'(stg_reg[k-1].quo[H-1:0])
                                       * WIDTH'(stg_reg[k-1].dvs[WIDTH-1:H]);
                    end
                    default: stg_next[k].p0 = '0;
                endcase
            end else if (k == 2 && stg_reg[k-1].cmd == CMD_MUL) begin
                stg_next[k].p0 = stg_reg[k-1].p0
                               + ((stg_reg[k-1].p1 + stg_reg[k-1].p2) << H);
            end
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    logic [WIDTH-1:0] res_out;
    logic [WIDTH-1:0] rem_out;

    assign res_out  = (stg_reg[NS-1].cmd == CMD_DIV) ? stg_reg[NS-1].quo : stg_reg[NS-1].p0;
    assign rem_out  = (stg_reg[NS-1].cmd == CMD_DIV) ? stg_reg[NS-1].rem : '0;
    assign m_tvalid = vld_reg[NS-1];
    assign m_tuser  = stg_reg[NS-1].dz;
    assign m_tdata  = DW'({rem_out, res_out});

    `IASMD_ASSERT_NOW(a_dz_all_ones, aclk, aresetn, m_tvalid && m_tuser, res_out == '1, "divide by zero must give all-ones quotient")
    `IASMD_ASSERT_NOW(a_rem_below_dvs, aclk, aresetn, m_tvalid && !m_tuser && stg_reg[NS-1].cmd == CMD_DIV, rem_out < stg_reg[NS-1].dvs, "remainder must be below divisor")
    `IASMD_ASSERT_NOW(a_rem_zero, aclk, aresetn, m_tvalid && stg_reg[NS-1].cmd != CMD_DIV, rem_out == '0 && !m_tuser, "non-divide must give zero remainder and no flag")
    `IASMD_ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid, "output must be empty after reset")
endmodule
`default_nettype wire
